FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/etlrt_pkg.sv
// Shared constants and codes for the learned rule table
package etlrt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_PIN_BITS    = 8;

    localparam int OP_BITS   = 3;
    localparam int PAGE_BITS = 8;
    localparam int STAT_BITS = 2;
    localparam int RC_BITS   = 7;
    localparam int COUNT_MAX = 127;

    localparam logic [OP_BITS-1:0] OP_READ   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_LEARN  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_SETOUT = 3'd4;
    localparam logic [OP_BITS-1:0] OP_COUNT  = 3'd5;

    localparam logic [PAGE_BITS-1:0] PAGE_EMPTY  = 8'd0;
    localparam logic [PAGE_BITS-1:0] PAGE_GLOBAL = 8'd1;

    localparam logic [STAT_BITS-1:0] STAT_ZERO   = 2'd0;
    localparam logic [STAT_BITS-1:0] RD_NO_EDGE  = 2'd0;
    localparam logic [STAT_BITS-1:0] RD_GLOBAL   = 2'd1;
    localparam logic [STAT_BITS-1:0] RD_LOCAL    = 2'd2;
    localparam logic [STAT_BITS-1:0] RD_UNKNOWN  = 2'd3;
    localparam logic [STAT_BITS-1:0] LN_NONE     = 2'd0;
    localparam logic [STAT_BITS-1:0] LN_CONFLICT = 2'd1;
    localparam logic [STAT_BITS-1:0] LN_ADDED    = 2'd2;
    localparam logic [STAT_BITS-1:0] LN_FULL     = 2'd3;
    localparam logic [STAT_BITS-1:0] RM_NONE     = 2'd0;
    localparam logic [STAT_BITS-1:0] RM_REMOVED  = 2'd1;
    localparam logic [STAT_BITS-1:0] RM_ABSENT   = 2'd2;
    localparam logic [STAT_BITS-1:0] CL_EMPTY    = 2'd0;
    localparam logic [STAT_BITS-1:0] CL_DELETED  = 2'd1;

endpackage

FILE: hdl/etlrt_ram.sv
// Generic single-write, single-read RAM with registered read data
module etlrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/edge_triggered_learned_rule_table.sv
// Top level of the edge-triggered learned rule table
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+---------------------
//  in      | op, pin_value, next_output, rule_page     | in_valid & in_ready
//  out     | out_bits, status, rule_count              | out_valid & out_ready
//
// Read, learn and remove scan the rule RAM one entry per cycle through a single
// match comparator, stopping at the first match; read and learn scan only on an edge.
// Clear all sweeps the RAM; set output, count and unused codes go straight to finishing.
// After reset a clearing sweep of every RAM entry runs with in_ready low.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted, and a stalled output holds the sequencer.
module edge_triggered_learned_rule_table #(
    parameter int TABLE_DEPTH = etlrt_pkg::DEF_TABLE_DEPTH,
    parameter int PIN_BITS    = etlrt_pkg::DEF_PIN_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [etlrt_pkg::OP_BITS-1:0]    op,
    input  logic [PIN_BITS-1:0]              pin_value,
    input  logic [PIN_BITS-1:0]              next_output,
    input  logic [etlrt_pkg::PAGE_BITS-1:0]  rule_page,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [PIN_BITS-1:0]              out_bits,
    output logic [etlrt_pkg::STAT_BITS-1:0]  status,
    output logic [etlrt_pkg::RC_BITS-1:0]    rule_count
);

    import etlrt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int P  = PIN_BITS;
    localparam int EW = PAGE_BITS + 5 * P;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FINISH = 4'b0100,
        S_CLEAR  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 chk_reg, chk_next;
    logic                 init_reg, init_next;
    logic [P-1:0]         prev_reg, prev_next;
    logic [P-1:0]         cur_reg, cur_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 hit_reg, hit_next;
    logic                 empty_found_reg, empty_found_next;
    logic                 out_valid_reg, out_valid_next;

    logic [OP_BITS-1:0]   op_reg, op_next;
    logic [P-1:0]         pin_reg, pin_next;
    logic [P-1:0]         nxt_reg, nxt_next;
    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic [P-1:0]         hl_reg, hl_next;
    logic [P-1:0]         lh_reg, lh_next;
    logic                 edge_reg, edge_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 hit_glob_reg, hit_glob_next;
    logic [P-1:0]         hit_fb_reg, hit_fb_next;
    logic [P-1:0]         hit_clr_reg, hit_clr_next;
    logic [P-1:0]         hit_set_reg, hit_set_next;
    logic [AW-1:0]        empty_idx_reg, empty_idx_next;
    logic [P-1:0]         out_bits_reg, out_bits_next;
    logic [STAT_BITS-1:0] status_reg, status_next;
    logic [RC_BITS-1:0]   count_out_reg, count_out_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [EW-1:0]        wdata;
    logic [EW-1:0]        rdata;

    logic [PAGE_BITS-1:0] e_page;
    logic [P-1:0]         e_fb, e_fall, e_rise, e_clr, e_set;
    logic                 e_empty, e_match;
    logic [P-1:0]         in_hl, in_lh;
    logic                 out_free;
    logic [31:0]          count_ext;

    etlrt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign e_set   = rdata[P-1:0];
    assign e_clr   = rdata[2*P-1:P];
    assign e_rise  = rdata[3*P-1:2*P];
    assign e_fall  = rdata[4*P-1:3*P];
    assign e_fb    = rdata[5*P-1:4*P];
    assign e_page  = rdata[EW-1:5*P];
    assign e_empty = (e_page == PAGE_EMPTY);
    assign e_match = !e_empty && (e_fall == hl_reg) && (e_rise == lh_reg)
                     && ((e_page == PAGE_GLOBAL) || (e_fb == cur_reg));

    assign in_hl     = (prev_reg ^ pin_value) & prev_reg;
    assign in_lh     = (prev_reg ^ pin_value) & pin_value;
    assign out_free  = !out_valid_reg || out_ready;
    assign count_ext = 32'(count_reg);

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        chk_next         = chk_reg;
        init_next        = init_reg;
        prev_next        = prev_reg;
        cur_next         = cur_reg;
        count_next       = count_reg;
        hit_next         = hit_reg;
        empty_found_next = empty_found_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        pin_next         = pin_reg;
        nxt_next         = nxt_reg;
        pg_next          = pg_reg;
        hl_next          = hl_reg;
        lh_next          = lh_reg;
        edge_next        = edge_reg;
        idx_next         = idx_reg;
        hit_idx_next     = hit_idx_reg;
        hit_glob_next    = hit_glob_reg;
        hit_fb_next      = hit_fb_reg;
        hit_clr_next     = hit_clr_reg;
        hit_set_next     = hit_set_reg;
        empty_idx_next   = empty_idx_reg;
        out_bits_next    = out_bits_reg;
        status_next      = status_reg;
        count_out_next   = count_out_reg;
        we               = 1'b0;
        waddr            = addr_reg;
        wdata            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next          = op;
                    pin_next         = pin_value;
                    nxt_next         = next_output;
                    pg_next          = rule_page;
                    hl_next          = in_hl;
                    lh_next          = in_lh;
                    edge_next        = (in_hl != '0) || (in_lh != '0);
                    addr_next        = '0;
                    chk_next         = 1'b0;
                    hit_next         = 1'b0;
                    empty_found_next = 1'b0;
                    if ((op == OP_READ && edge_next)
                        || (op == OP_LEARN && edge_next && rule_page != PAGE_EMPTY)
                        || (op == OP_REMOVE))
                    begin
                        state_next = S_SCAN;
                    end
                    else if (op == OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                chk_next = 1'b1;
                idx_next = addr_reg;
                if (addr_reg != LAST)
                begin
                    addr_next = addr_reg + AW'(1);
                end
                if (chk_reg)
                begin
                    if (e_empty && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = idx_reg;
                    end
                    if (e_match)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = idx_reg;
                        hit_glob_next = (e_page == PAGE_GLOBAL);
                        hit_fb_next   = e_fb;
                        hit_clr_next  = e_clr;
                        hit_set_next  = e_set;
                        state_next    = S_FINISH;
                    end
                    else if (idx_reg == LAST)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = addr_reg;
                wdata = '0;
                if (addr_reg == LAST)
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_FINISH;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    status_next    = STAT_ZERO;
                    count_out_next = '0;
                    case (op_reg)
                        OP_READ:
                        begin
                            if (!edge_reg)
                            begin
                                status_next = RD_NO_EDGE;
                            end
                            else if (hit_reg)
                            begin
                                prev_next   = pin_reg;
                                cur_next    = (hit_fb_reg | hit_set_reg) & ~hit_clr_reg;
                                status_next = hit_glob_reg ? RD_GLOBAL : RD_LOCAL;
                            end
                            else
                            begin
                                prev_next   = pin_reg;
                                status_next = RD_UNKNOWN;
                            end
                        end
                        OP_LEARN:
                        begin
                            if (!edge_reg || pg_reg == PAGE_EMPTY)
                            begin
                                status_next = LN_NONE;
                            end
                            else if (hit_reg)
                            begin
                                status_next = LN_CONFLICT;
                            end
                            else if (empty_found_reg)
                            begin
                                we          = 1'b1;
                                waddr       = empty_idx_reg;
                                wdata       = {pg_reg, cur_reg, hl_reg, lh_reg,
                                               (cur_reg ^ nxt_reg) & cur_reg,
                                               (cur_reg ^ nxt_reg) & nxt_reg};
                                count_next  = count_reg + CW'(1);
                                status_next = LN_ADDED;
                            end
                            else
                            begin
                                status_next = LN_FULL;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                we          = 1'b1;
                                waddr       = hit_idx_reg;
                                wdata       = '0;
                                count_next  = count_reg - CW'(1);
                                status_next = RM_REMOVED;
                            end
                            else if (count_ext < 32'(TABLE_DEPTH))
                            begin
                                status_next = RM_ABSENT;
                            end
                            else
                            begin
                                status_next = RM_NONE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            status_next = (count_reg != '0) ? CL_DELETED : CL_EMPTY;
                            count_next  = '0;
                            cur_next    = '0;
                        end
                        OP_SETOUT:
                        begin
                            cur_next = pin_reg;
                        end
                        OP_COUNT:
                        begin
                            count_out_next = (count_ext > 32'(COUNT_MAX))
                                             ? RC_BITS'(COUNT_MAX) : count_ext[RC_BITS-1:0];
                        end
                        default:
                        begin
                            status_next = STAT_ZERO;
                        end
                    endcase
                    out_bits_next  = cur_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            addr_reg        <= '0;
            chk_reg         <= 1'b0;
            init_reg        <= 1'b1;
            prev_reg        <= '0;
            cur_reg         <= '0;
            count_reg       <= '0;
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            chk_reg         <= chk_next;
            init_reg        <= init_next;
            prev_reg        <= prev_next;
            cur_reg         <= cur_next;
            count_reg       <= count_next;
            hit_reg         <= hit_next;
            empty_found_reg <= empty_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pin_reg       <= pin_next;
        nxt_reg       <= nxt_next;
        pg_reg        <= pg_next;
        hl_reg        <= hl_next;
        lh_reg        <= lh_next;
        edge_reg      <= edge_next;
        idx_reg       <= idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_glob_reg  <= hit_glob_next;
        hit_fb_reg    <= hit_fb_next;
        hit_clr_reg   <= hit_clr_next;
        hit_set_reg   <= hit_set_next;
        empty_idx_reg <= empty_idx_next;
        out_bits_reg  <= out_bits_next;
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_bits   = out_bits_reg;
    assign status     = status_reg;
    assign rule_count = count_out_reg;

endmodule

FILE: hdl/etlrt_checker.sv
// Port-level checker for the learned rule table, bound to the top level
`include "assert_macros.svh"

module etlrt_checker #(
    parameter int TABLE_DEPTH = etlrt_pkg::DEF_TABLE_DEPTH,
    parameter int PIN_BITS    = etlrt_pkg::DEF_PIN_BITS
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [PIN_BITS-1:0]             out_bits,
    input logic [etlrt_pkg::STAT_BITS-1:0] status,
    input logic [etlrt_pkg::RC_BITS-1:0]   rule_count
);

    import etlrt_pkg::*;

    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready)

    `ASSERT_IMPL(a_count_bounded, clk, rst_n, out_valid,
                 32'(rule_count) <= 32'(TABLE_DEPTH))

    `ASSERT_IMPL(a_count_status_zero, clk, rst_n, out_valid && rule_count != '0,
                 status == STAT_ZERO)

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(out_bits) && $stable(status) && $stable(rule_count))

endmodule

bind edge_triggered_learned_rule_table etlrt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PIN_BITS    (PIN_BITS)
) u_etlrt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_bits   (out_bits),
    .status     (status),
    .rule_count (rule_count)
);
